// ===== hw/rtl/udb_pkg.sv =====
// Shared types and constants for the UART register datagram builder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package udb_pkg;

  // Request opcodes
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 4;
  localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_NIBBLE     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RESERVED_NIBBLE = 2'd1;
  localparam logic [3:0] SYNC_NIBBLE_RESET     = 4'd5;
  localparam logic [3:0] RESERVED_NIBBLE_RESET = 4'd0;

  // CRC-8 generator polynomial
  localparam logic [7:0] CRC_POLY = 8'h07;

  // Byte slots held per request (header, address, register, four data bytes, spare)
  localparam int FRAME_SLOTS = 8;

  // Request queue depth between front and back
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  slave_addr;
    logic [6:0]  reg_addr;
    logic [31:0] write_data;
  } udb_in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } udb_out_t;

  // Classified request: frame body bytes ready for the serializer
  typedef struct packed {
    logic                            is_write;
    logic [FRAME_SLOTS-1:0][7:0]     bytes;
  } udb_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } udb_queue_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/udb_front.sv =====
// Front end: accepts requests, holds the configuration registers and
// builds the frame body bytes. Depends on udb_pkg.
`default_nettype none

module udb_front (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire  udb_pkg::udb_in_t              in_item,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [udb_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire  [udb_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire  udb_pkg::udb_queue_status_t    q_status,
  output logic                                push,
  output udb_pkg::udb_entry_t                 push_entry
);
  import udb_pkg::*;

  logic       sync_nibble;
  logic [3:0] sync_reg;
  logic [3:0] reserved_reg;
  logic       held;
  logic       accept;
  udb_entry_t build;

  assign sync_nibble = 1'b0;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_reg     <= SYNC_NIBBLE_RESET;
      reserved_reg <= RESERVED_NIBBLE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SYNC_NIBBLE:     sync_reg     <= cfg_data[3:0] | {4{sync_nibble}};
        CFG_RESERVED_NIBBLE: reserved_reg <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Hold the request while the queue is full
  assign push     = held && !q_status.full;
  assign in_stall = held && q_status.full;
  assign accept   = in_valid && !in_stall;

  // Build the frame body from the request fields
  always_comb begin
    build.is_write = (in_item.opcode == OP_WRITE);
    build.bytes[0] = {reserved_reg, sync_reg};
    build.bytes[1] = in_item.slave_addr;
    build.bytes[2] = {(in_item.opcode == OP_WRITE), in_item.reg_addr};
    build.bytes[3] = in_item.write_data[31:24];
    build.bytes[4] = in_item.write_data[23:16];
    build.bytes[5] = in_item.write_data[15:8];
    build.bytes[6] = in_item.write_data[7:0];
    build.bytes[7] = 8'h00;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= accept || (held && !push);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      push_entry <= build;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/udb_queue.sv =====
// Short request queue between the front end and the byte serializer.
// Depends on udb_pkg for the entry and status types.
`default_nettype none

module udb_queue #(
  parameter int DEPTH = udb_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         push,
  input  wire udb_pkg::udb_entry_t    push_entry,
  input  wire                         pop,
  output udb_pkg::udb_entry_t         pop_entry,
  output udb_pkg::udb_queue_status_t  status
);
  import udb_pkg::*;

  localparam int PtrW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CountW = $clog2(DEPTH + 1);

  udb_entry_t        slots [DEPTH];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CountW-1:0] count;

  assign status.full  = (count == CountW'(DEPTH));
  assign status.empty = (count == '0);
  assign pop_entry    = slots[rd_ptr];

  // Store on push
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/udb_back.sv =====
// Back end: serializes one queued frame a byte per cycle unless the output stalls,
// folds each byte into the CRC-8 and appends it. Depends on udb_pkg.
`default_nettype none

module udb_back (
  input  wire                              clk,
  input  wire                              rst,
  input  wire udb_pkg::udb_queue_status_t  q_status,
  input  wire udb_pkg::udb_entry_t         pop_entry,
  output logic                             pop,
  output logic                             out_valid,
  input  wire                              out_stall,
  output udb_pkg::udb_out_t                out_item
);
  import udb_pkg::*;

  localparam logic [2:0] ReadLastIdx  = 3'd3;
  localparam logic [2:0] WriteLastIdx = 3'd7;

  // One byte of CRC-8, bits taken least significant first
  function automatic logic [7:0] crc8_update(input logic [7:0] crc_in,
                                             input logic [7:0] data);
    logic [7:0] c;
    logic       fb;
    c = crc_in;
    for (int k = 0; k < 8; k++) begin
      fb = c[7] ^ data[k];
      c  = {c[6:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  udb_entry_t entry;
  logic       busy;
  logic [2:0] idx;
  logic [7:0] crc;
  logic [7:0] crc_next;
  logic [7:0] cur_byte;
  logic       is_last;
  logic       advance;
  logic       emit;

  always_comb begin
    is_last  = (idx == (entry.is_write ? WriteLastIdx : ReadLastIdx));
    crc_next = crc8_update(crc, entry.bytes[idx]);
    cur_byte = is_last ? crc : entry.bytes[idx];
    advance  = !out_valid || !out_stall;
    emit     = busy && advance;
    pop      = !q_status.empty && (!busy || (emit && is_last));
  end

  // Control: frame in progress and output register occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= busy;
      end
      if (pop) begin
        busy <= 1'b1;
      end else if (emit && is_last) begin
        busy <= 1'b0;
      end
    end
  end

  // Load a new frame or step to the next byte
  always_ff @(posedge clk) begin
    if (pop) begin
      entry <= pop_entry;
      idx   <= '0;
      crc   <= '0;
    end else if (emit) begin
      idx <= idx + 1'b1;
      crc <= crc_next;
    end
    if (emit) begin
      out_item.frame_byte <= cur_byte;
      out_item.last_byte  <= is_last;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/uart_register_datagram_builder.sv =====
// UART register datagram builder, top level.
// Depends on udb_pkg, udb_front, udb_queue and udb_back.
// Usage:
//   in channel  (in_valid / in_stall / in_item): one register request per item.
//   out channel (out_valid / out_stall / out_item): one datagram byte per item,
//     last_byte marks the CRC byte that closes a frame.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 sets
//     the sync nibble, index 1 the reserved nibble; other indexes are ignored.
//     cfg_ready is always high. Write only while the block is idle.
// Timing:
//   The first byte of a frame passes the front register, a queue slot, the
//   serializer entry register and the output register before it shows. A
//   read frame has 4 bytes, a write frame 8 bytes; the serializer emits one
//   byte per cycle while out_stall is low, and the next frame follows the
//   last byte with no gap. A front register and a queue of QUEUE_DEPTH
//   requests keep taking requests while the output is stalled.
// Reset:
//   rst is synchronous; it empties the queue and the output register and
//   sets the sync nibble to 5 and the reserved nibble to 0. While out_stall
//   is high with out_valid set, the output byte holds and the serializer waits.
`default_nettype none

module uart_register_datagram_builder #(
  parameter int QUEUE_DEPTH = udb_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  udb_pkg::udb_in_t           in_item,
  output logic                             out_valid,
  input  wire                              out_stall,
  output udb_pkg::udb_out_t                out_item,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [udb_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire  [udb_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import udb_pkg::*;

  udb_queue_status_t q_status;
  udb_entry_t        push_entry;
  udb_entry_t        pop_entry;
  logic              push;
  logic              pop;

  udb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  udb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .status     (q_status)
  );

  udb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .pop_entry (pop_entry),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

`ifndef SYNTHESIS
  // Never write into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push && q_status.full))
    else $error("request pushed into full queue");

  // Never read from an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(pop && q_status.empty))
    else $error("request popped from empty queue");

  // A request is only held back while the queue is full
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_status.full)
    else $error("input stalled with room in queue");
`endif

endmodule

`default_nettype wire
